/* rtl/set_assoc_cache_lru_sim_core_assert.svh */
// assertion macros for the cache tag store checker
// no dependencies; clk_i and rst_ni must be visible where these are used
`ifndef SET_ASSOC_CACHE_LRU_SIM_CORE_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_SIM_CORE_ASSERT_SVH

// same-cycle implication
`define SACL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cache core check failed");

// next-cycle implication
`define SACL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cache core check failed");

`endif

/* rtl/sacl_pkg.sv */
// shared types, codes and defaults for the set-associative cache tag store
// no dependencies
package sacl_pkg;

  localparam int unsigned DEF_MAX_SET_BITS = 6;
  localparam int unsigned DEF_MAX_WAYS     = 8;
  localparam int unsigned DEF_ADDR_WIDTH   = 64;
  localparam int unsigned MAX_BLOCK_BITS   = 12;
  localparam int unsigned STAMP_W          = 32;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_STORE  = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;

  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_MISS  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  localparam logic [1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [1:0] CFG_WAYS       = 2'd1;
  localparam logic [1:0] CFG_BLOCK_BITS = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] addr;
  } sacl_req_t;

  typedef struct packed {
    logic [1:0]  first_outcome;
    logic        second_valid;
    logic [1:0]  second_outcome;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] eviction_total;
  } sacl_rsp_t;

endpackage

/* rtl/set_assoc_cache_lru_sim_core.sv */
// top level of the set-associative cache tag store with lru replacement
// depends on sacl_pkg, sacl_front and sacl_back
//
// Requests enter through a queue-like port: req_i is taken on a rising edge
// with push high and full low. Results leave the same way: rsp_o holds the
// oldest result while empty is low and is taken on an edge with pop high.
// Configuration (set bits, ways, block bits) is written through cfg_we_i,
// cfg_idx_i and cfg_data_i. The user must write it only while the block is
// idle; the block itself does not enforce this. In the back end a request
// passes a read state, reading its set row from the single-port row memory,
// then a compare state that compares tags, chooses the way and writes the
// row back; the next request is read only after that write-back.
// A two-entry request queue keeps taking requests while a result waits;
// when the result register is not popped the back end holds its compare
// step and the queue fills, then full rises.
// Reset clears the per-row written flags at once, so the whole store reads
// as empty with no clearing pass; counters and stamps restart at zero.
module set_assoc_cache_lru_sim_core import sacl_pkg::*; #(
  parameter int unsigned MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter int unsigned MAX_WAYS     = DEF_MAX_WAYS,
  parameter int unsigned ADDR_WIDTH   = DEF_ADDR_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  sacl_req_t  req_i,
  output logic       empty,
  input  logic       pop,
  output sacl_rsp_t  rsp_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [3:0] cfg_data_i
);

  localparam int unsigned SET_IW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

  logic [2:0]            set_bits_q;
  logic [3:0]            ways_q;
  logic [3:0]            block_bits_q;
  logic [2:0]            sb_eff;
  logic [3:0]            ways_eff;
  logic [3:0]            bb_eff;
  logic                  q_vld, q_rdy, q_modify;
  logic [SET_IW-1:0]     q_set;
  logic [ADDR_WIDTH-1:0] q_tag;

  always_comb begin
    sb_eff   = (int'(set_bits_q) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits_q;
    bb_eff   = (int'(block_bits_q) > MAX_BLOCK_BITS) ? 4'(MAX_BLOCK_BITS) : block_bits_q;
    ways_eff = ways_q;
    if (ways_q == 4'd0) begin
      ways_eff = 4'd1;
    end else if (int'(ways_q) > MAX_WAYS) begin
      ways_eff = 4'(MAX_WAYS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= 3'd0;
      ways_q       <= 4'd1;
      block_bits_q <= 4'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SET_BITS:   set_bits_q   <= cfg_data_i[2:0];
        CFG_WAYS:       ways_q       <= cfg_data_i;
        CFG_BLOCK_BITS: block_bits_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sacl_front #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .ADDR_WIDTH  (ADDR_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .req_i     (req_i),
    .sb_i      (sb_eff),
    .bb_i      (bb_eff),
    .q_vld_o   (q_vld),
    .q_rdy_i   (q_rdy),
    .q_modify_o(q_modify),
    .q_set_o   (q_set),
    .q_tag_o   (q_tag)
  );

  sacl_back #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .MAX_WAYS    (MAX_WAYS),
    .ADDR_WIDTH  (ADDR_WIDTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ways_i    (ways_eff),
    .q_vld_i   (q_vld),
    .q_rdy_o   (q_rdy),
    .q_modify_i(q_modify),
    .q_set_i   (q_set),
    .q_tag_i   (q_tag),
    .pop_i     (pop),
    .empty_o   (empty),
    .rsp_o     (rsp_o)
  );

endmodule

/* rtl/sacl_front.sv */
// front end: splits the address into set and tag and queues the request
// depends on sacl_pkg
module sacl_front import sacl_pkg::*; #(
  parameter int unsigned MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter int unsigned ADDR_WIDTH   = DEF_ADDR_WIDTH,
  localparam int unsigned SET_IW     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  sacl_req_t             req_i,
  input  logic [2:0]            sb_i,
  input  logic [3:0]            bb_i,
  output logic                  q_vld_o,
  input  logic                  q_rdy_i,
  output logic                  q_modify_o,
  output logic [SET_IW-1:0]     q_set_o,
  output logic [ADDR_WIDTH-1:0] q_tag_o
);

  localparam int unsigned ENT_W = 1 + SET_IW + ADDR_WIDTH;

  logic [ADDR_WIDTH-1:0] addr;
  logic [ADDR_WIDTH-1:0] shifted;
  logic [SET_IW-1:0]     set_mask;
  logic [4:0]            tag_sh;
  logic [ENT_W-1:0]      ent;
  logic [ENT_W-1:0]      q_mem_q [2];
  logic                  wr_ptr_q, wr_ptr_d;
  logic                  rd_ptr_q, rd_ptr_d;
  logic [1:0]            cnt_q, cnt_d;
  logic                  do_push, do_pop;

  always_comb begin
    addr     = req_i.addr[ADDR_WIDTH-1:0];
    shifted  = addr >> bb_i;
    set_mask = ~({SET_IW{1'b1}} << sb_i);
    tag_sh   = {2'b00, sb_i} + {1'b0, bb_i};
    ent      = {(req_i.op == OP_MODIFY), shifted[SET_IW-1:0] & set_mask, addr >> tag_sh};
  end

  assign full_o  = (cnt_q == 2'd2);
  assign q_vld_o = (cnt_q != 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = q_rdy_i && q_vld_o;

  assign {q_modify_o, q_set_o, q_tag_o} = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem_q[wr_ptr_q] <= ent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

/* rtl/sacl_back.sv */
// back end: set row memory, tag compare, lru choice, write-back and totals
// depends on sacl_pkg
module sacl_back import sacl_pkg::*; #(
  parameter int unsigned MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter int unsigned MAX_WAYS     = DEF_MAX_WAYS,
  parameter int unsigned ADDR_WIDTH   = DEF_ADDR_WIDTH,
  localparam int unsigned SET_IW     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [3:0]            ways_i,
  input  logic                  q_vld_i,
  output logic                  q_rdy_o,
  input  logic                  q_modify_i,
  input  logic [SET_IW-1:0]     q_set_i,
  input  logic [ADDR_WIDTH-1:0] q_tag_i,
  input  logic                  pop_i,
  output logic                  empty_o,
  output sacl_rsp_t             rsp_o
);

  localparam int unsigned NUM_ROWS = 1 << MAX_SET_BITS;
  localparam int unsigned ENT_W    = 1 + ADDR_WIDTH + STAMP_W;
  localparam int unsigned ROW_W    = MAX_WAYS * ENT_W;
  localparam int unsigned WAY_IW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  localparam logic ST_READ = 1'b0;
  localparam logic ST_CMP  = 1'b1;

  logic [ROW_W-1:0]      mem_q [NUM_ROWS];
  logic [NUM_ROWS-1:0]   row_vld_q;
  logic [ROW_W-1:0]      rd_row_q;
  logic                  rd_flag_q;
  logic [SET_IW-1:0]     cur_set_q;
  logic [ADDR_WIDTH-1:0] cur_tag_q;
  logic                  cur_mod_q;
  logic                  st_q, st_d;
  logic [31:0]           acc_q, acc_d;
  logic [31:0]           hit_q, hit_d;
  logic [31:0]           miss_q, miss_d;
  logic [31:0]           evict_q, evict_d;
  logic                  out_vld_q, out_vld_d;
  sacl_rsp_t             rsp_q, rsp_d;

  logic [ROW_W-1:0]      row;
  logic [ROW_W-1:0]      new_row;
  logic                  hit, inv, evict;
  logic [WAY_IW-1:0]     hit_way, inv_way, lru_way, way_sel;
  logic [STAMP_W-1:0]    lru_stamp;
  logic                  re, we, out_free;

  assign q_rdy_o  = (st_q == ST_READ);
  assign re       = (st_q == ST_READ) && q_vld_i;
  assign out_free = !out_vld_q || pop_i;
  assign we       = (st_q == ST_CMP) && out_free;
  assign empty_o  = !out_vld_q;
  assign rsp_o    = rsp_q;

  // an unwritten row reads as all ways invalid
  assign row = rd_flag_q ? rd_row_q : '0;

  always_comb begin
    logic             v;
    logic [ADDR_WIDTH-1:0] t;
    logic [STAMP_W-1:0] s;
    hit       = 1'b0;
    inv       = 1'b0;
    hit_way   = '0;
    inv_way   = '0;
    lru_way   = '0;
    lru_stamp = row[STAMP_W-1:0];
    for (int w = 0; w < MAX_WAYS; w++) begin
      v = row[w*ENT_W + ENT_W - 1];
      t = row[w*ENT_W + STAMP_W +: ADDR_WIDTH];
      s = row[w*ENT_W +: STAMP_W];
      if (w < int'(ways_i)) begin
        if (v && (t == cur_tag_q) && !hit) begin
          hit     = 1'b1;
          hit_way = WAY_IW'(w);
        end
        if (!v && !inv) begin
          inv     = 1'b1;
          inv_way = WAY_IW'(w);
        end
        // strict less keeps the lowest way on a tie
        if (w > 0 && s < lru_stamp) begin
          lru_stamp = s;
          lru_way   = WAY_IW'(w);
        end
      end
    end
    evict   = !hit && !inv;
    way_sel = hit ? hit_way : (inv ? inv_way : lru_way);
  end

  always_comb begin
    acc_d   = acc_q + 32'd1 + {31'd0, cur_mod_q};
    hit_d   = hit_q + {31'd0, hit} + {31'd0, cur_mod_q};
    miss_d  = miss_q + {31'd0, !hit};
    evict_d = evict_q + {31'd0, evict};
    new_row = row;
    new_row[way_sel*ENT_W +: ENT_W] = {1'b1, cur_tag_q, acc_d};
    rsp_d.first_outcome  = hit ? OUT_HIT : (evict ? OUT_EVICT : OUT_MISS);
    rsp_d.second_valid   = cur_mod_q;
    rsp_d.second_outcome = OUT_HIT;
    rsp_d.hit_total      = hit_d;
    rsp_d.miss_total     = miss_d;
    rsp_d.eviction_total = evict_d;
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_READ: begin
        if (q_vld_i) st_d = ST_CMP;
      end
      ST_CMP: begin
        if (out_free) st_d = ST_READ;
      end
      default: st_d = ST_READ;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (we) begin
      out_vld_d = 1'b1;
    end else if (pop_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[cur_set_q] <= new_row;
    end
    if (re) begin
      rd_row_q  <= mem_q[q_set_i];
      cur_set_q <= q_set_i;
      cur_tag_q <= q_tag_i;
      cur_mod_q <= q_modify_i;
    end
    if (we) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_flag_q <= 1'b0;
      st_q      <= ST_READ;
      acc_q     <= '0;
      hit_q     <= '0;
      miss_q    <= '0;
      evict_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      out_vld_q <= out_vld_d;
      if (re) begin
        rd_flag_q <= row_vld_q[q_set_i];
      end
      if (we) begin
        row_vld_q[cur_set_q] <= 1'b1;
        acc_q   <= acc_d;
        hit_q   <= hit_d;
        miss_q  <= miss_d;
        evict_q <= evict_d;
      end
    end
  end

endmodule

/* rtl/sacl_checker.sv */
// port-level checks on the cache tag store result channel, bound to the top
// depends on sacl_pkg and set_assoc_cache_lru_sim_core_assert.svh
`include "set_assoc_cache_lru_sim_core_assert.svh"

module sacl_checker import sacl_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      empty_i,
  input logic      pop_i,
  input sacl_rsp_t rsp_i
);

  // the store half of a modify always hits, and is zero otherwise
  `SACL_ASSERT_IMP(a_second_hit, !empty_i, rsp_i.second_outcome == OUT_HIT)

  // the first outcome never takes the unused code
  `SACL_ASSERT_IMP(a_first_code, !empty_i, rsp_i.first_outcome <= OUT_EVICT)

  // a waiting result stays until popped
  `SACL_ASSERT_NXT(a_hold_valid, !empty_i && !pop_i, !empty_i)

  // and its contents do not move
  `SACL_ASSERT_NXT(a_hold_data, !empty_i && !pop_i, $stable(rsp_i))

endmodule

bind set_assoc_cache_lru_sim_core sacl_checker u_sacl_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .empty_i(empty),
  .pop_i  (pop),
  .rsp_i  (rsp_o)
);

/* tb/sacl_tb_pkg.sv */
`timescale 1ns / 1ps
// scoreboard for the cache tag store: an lru tag model and the queue of expected results
// depends on sacl_pkg for the request and result types and the outcome codes
package sacl_tb_pkg;
  import sacl_pkg::*;

  localparam int unsigned NUM_LINES = (1 << DEF_MAX_SET_BITS) * DEF_MAX_WAYS;

  // codes the package leaves unnamed
  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  localparam logic [1:0] CFG_SPARE  = 2'd3;

  class lru_tag_scoreboard;
    bit          line_valid [NUM_LINES];
    logic [63:0] line_tag   [NUM_LINES];
    logic [31:0] line_stamp [NUM_LINES];
    logic [31:0] stamp_now;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evictions;
    logic [2:0]  reg_set_bits;
    logic [3:0]  reg_ways;
    logic [3:0]  reg_block_bits;
    sacl_rsp_t   pending_rsp [$];
    int unsigned errors;
    int unsigned results_seen;

    function new();
      for (int i = 0; i < NUM_LINES; i++) begin
        line_valid[i] = 1'b0;
        line_tag[i]   = '0;
        line_stamp[i] = '0;
      end
      stamp_now      = '0;
      hits           = '0;
      misses         = '0;
      evictions      = '0;
      reg_set_bits   = 3'd0;
      reg_ways       = 4'd1;
      reg_block_bits = 4'd0;
      errors         = 0;
      results_seen   = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [3:0] data);
      case (idx)
        CFG_SET_BITS:   reg_set_bits   = data[2:0];
        CFG_WAYS:       reg_ways       = data;
        CFG_BLOCK_BITS: reg_block_bits = data;
        default: ;
      endcase
    endfunction

    // one lookup with fill or lru eviction, returns the outcome code
    function logic [1:0] access_line(logic [63:0] addr);
      int unsigned set_w;
      int unsigned blk_w;
      int unsigned ways;
      int unsigned base;
      int unsigned victim;
      logic [63:0] amask;
      logic [63:0] a;
      logic [63:0] tag;
      set_w = (reg_set_bits > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : reg_set_bits;
      blk_w = (reg_block_bits > MAX_BLOCK_BITS) ? MAX_BLOCK_BITS : reg_block_bits;
      ways  = (reg_ways == 0) ? 1 : ((reg_ways > DEF_MAX_WAYS) ? DEF_MAX_WAYS : reg_ways);
      amask = (DEF_ADDR_WIDTH >= 64) ? '1 : ((64'd1 << DEF_ADDR_WIDTH) - 64'd1);
      a     = addr & amask;
      base  = int'((a >> blk_w) & ((64'd1 << set_w) - 64'd1)) * DEF_MAX_WAYS;
      tag   = a >> (blk_w + set_w);
      stamp_now = stamp_now + 32'd1;
      for (int w = 0; w < ways; w++) begin
        if (line_valid[base + w] && line_tag[base + w] == tag) begin
          line_stamp[base + w] = stamp_now;
          hits = hits + 32'd1;
          return OUT_HIT;
        end
      end
      for (int w = 0; w < ways; w++) begin
        if (!line_valid[base + w]) begin
          line_valid[base + w] = 1'b1;
          line_tag[base + w]   = tag;
          line_stamp[base + w] = stamp_now;
          misses = misses + 32'd1;
          return OUT_MISS;
        end
      end
      // ties keep the lowest way
      victim = 0;
      for (int w = 1; w < ways; w++) begin
        if (line_stamp[base + w] < line_stamp[base + victim]) victim = w;
      end
      line_tag[base + victim]   = tag;
      line_stamp[base + victim] = stamp_now;
      misses    = misses + 32'd1;
      evictions = evictions + 32'd1;
      return OUT_EVICT;
    endfunction

    function void note_request(sacl_req_t req);
      sacl_rsp_t want;
      want = '0;
      want.first_outcome = access_line(req.addr);
      if (req.op == OP_MODIFY) begin
        want.second_valid   = 1'b1;
        want.second_outcome = access_line(req.addr);
      end
      want.hit_total      = hits;
      want.miss_total     = misses;
      want.eviction_total = evictions;
      pending_rsp.push_back(want);
    endfunction

    function int unsigned outstanding();
      return pending_rsp.size();
    endfunction

    task report(string msg);
      $display("mismatch at result %0d: %s", results_seen, msg);
      errors++;
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task check_response(sacl_rsp_t got);
      sacl_rsp_t want;
      if (pending_rsp.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        want = pending_rsp.pop_front();
        check_field("first_outcome", 32'(got.first_outcome), 32'(want.first_outcome));
        check_field("second_valid", 32'(got.second_valid), 32'(want.second_valid));
        check_field("second_outcome", 32'(got.second_outcome), 32'(want.second_outcome));
        check_field("hit_total", got.hit_total, want.hit_total);
        check_field("miss_total", got.miss_total, want.miss_total);
        check_field("eviction_total", got.eviction_total, want.eviction_total);
      end
      results_seen++;
    endtask
  endclass

endpackage

/* tb/tb.sv */
`timescale 1ns / 1ps
// top-level bench for set_assoc_cache_lru_sim_core: drives requests and geometry writes
// depends on sacl_pkg and on sacl_tb_pkg for the lru scoreboard
module tb;
  import sacl_pkg::*;
  import sacl_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       push       = 1'b0;
  logic       full;
  sacl_req_t  req_i      = '0;
  logic       empty;
  logic       pop        = 1'b0;
  sacl_rsp_t  rsp_o;
  logic       cfg_we_i   = 1'b0;
  logic [1:0] cfg_idx_i  = CFG_SET_BITS;
  logic [3:0] cfg_data_i = 4'd0;

  lru_tag_scoreboard board = new();

  int unsigned cycle_count = 0;
  int unsigned stall_left  = 0;
  bit          quiet_tx    = 1'b0;
  bit          quiet_rx    = 1'b0;
  int unsigned geo_sb      = 0;
  int unsigned geo_bb      = 0;
  int unsigned geo_ways    = 1;
  logic [63:0] far_tag [2];

  set_assoc_cache_lru_sim_core dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .req_i     (req_i),
    .empty     (empty),
    .pop       (pop),
    .rsp_o     (rsp_o),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[set_assoc_cache_lru_sim_core] ERROR");
      $finish;
    end
  end

  // result side: stalls come in short bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      pop <= 1'b0;
    end else if (!quiet_rx && $urandom_range(99) < 3) begin
      stall_left <= $urandom_range(5, 1);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) board.write_reg(cfg_idx_i, cfg_data_i);
      if (pop && !empty) board.check_response(rsp_o);
      if (push && !full) board.note_request(req_i);
    end
  end

  // push stays high across back-to-back requests
  task automatic send_req(logic [1:0] op, logic [63:0] addr);
    sacl_req_t req;
    int unsigned gap;
    req.op   = op;
    req.addr = addr;
    gap = 0;
    if (!quiet_tx && $urandom_range(99) < 15) gap = $urandom_range(3, 1);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push  <= 1'b1;
    req_i <= req;
    do @(posedge clk_i); while (full);
  endtask

  task automatic drain();
    push <= 1'b0;
    do @(posedge clk_i); while (board.outstanding() != 0);
  endtask

  task automatic set_geometry(logic [3:0] sb_val, logic [3:0] ways_val, logic [3:0] bb_val);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_SET_BITS;
    cfg_data_i <= sb_val;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_WAYS;
    cfg_data_i <= ways_val;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_BLOCK_BITS;
    cfg_data_i <= bb_val;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SPARE;
    cfg_data_i <= 4'($urandom);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    geo_sb   = (sb_val[2:0] > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : sb_val[2:0];
    geo_ways = (ways_val == 0) ? 1 : ((ways_val > DEF_MAX_WAYS) ? DEF_MAX_WAYS : ways_val);
    geo_bb   = (bb_val > MAX_BLOCK_BITS) ? MAX_BLOCK_BITS : bb_val;
    far_tag[0] = {$urandom, $urandom};
    far_tag[1] = {$urandom, $urandom};
  endtask

  // mostly a few tags over a few sets so that hits and evictions both occur
  function automatic logic [63:0] make_addr();
    logic [63:0] tag_part;
    logic [63:0] set_part;
    logic [63:0] offs_part;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return {$urandom, $urandom};
    if (pick < 20) tag_part = far_tag[$urandom_range(1)];
    else tag_part = 64'($urandom_range(geo_ways + 3));
    set_part  = ($urandom_range(3) == 0) ? 64'($urandom) : 64'($urandom_range(3));
    set_part  = set_part & ((64'd1 << geo_sb) - 64'd1);
    offs_part = 64'($urandom) & ((64'd1 << geo_bb) - 64'd1);
    return (tag_part << (geo_bb + geo_sb)) | (set_part << geo_bb) | offs_part;
  endfunction

  task automatic random_phase(int unsigned n);
    for (int i = 0; i < n; i++) send_req(2'($urandom_range(3)), make_addr());
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset geometry holds a single line
    send_req(OP_LOAD, 64'd0);
    send_req(OP_LOAD, 64'd0);
    send_req(OP_STORE, 64'd0);
    send_req(OP_MODIFY, 64'd1);
    send_req(OP_UNKNOWN, 64'd1);
    send_req(OP_LOAD, '1);
    send_req(OP_MODIFY, '1);
    send_req(OP_STORE, 64'h8000_0000_0000_0000);

    // widest legal geometry, old lines read with the new split
    set_geometry(4'd6, 4'd8, 4'd12);
    send_req(OP_LOAD, 64'd0);
    send_req(OP_LOAD, 64'hfff);
    send_req(OP_STORE, 64'h1000);
    send_req(OP_MODIFY, 64'h3f000);
    for (int k = 1; k <= 9; k++) send_req(OP_LOAD, 64'(k) << 18);
    send_req(OP_LOAD, 64'd0);

    // out-of-range values saturate, zero ways acts as one
    set_geometry(4'd7, 4'd0, 4'd15);
    send_req(OP_LOAD, '1);
    send_req(OP_LOAD, 64'h5555_5555_5555_5555);
    send_req(OP_MODIFY, 64'haaaa_aaaa_aaaa_aaaa);

    set_geometry(4'd0, 4'd1, 4'd0);
    random_phase(90);
    set_geometry(4'd6, 4'd8, 4'd12);
    random_phase(90);
    set_geometry(4'd7, 4'd15, 4'd15);
    quiet_tx = 1'b1;
    random_phase(90);
    set_geometry(4'd2, 4'd0, 4'd13);
    quiet_tx = 1'b0;
    quiet_rx = 1'b1;
    random_phase(90);
    set_geometry(4'd3, 4'd2, 4'd4);
    quiet_tx = 1'b1;
    random_phase(90);
    quiet_tx = 1'b0;
    quiet_rx = 1'b0;
    for (int p = 0; p < 3; p++) begin
      set_geometry(4'($urandom), 4'($urandom), 4'($urandom));
      random_phase(90);
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("[set_assoc_cache_lru_sim_core] OK");
    end else begin
      $display("[set_assoc_cache_lru_sim_core] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/sacl_pkg.sv
rtl/sacl_front.sv
rtl/sacl_back.sv
rtl/set_assoc_cache_lru_sim_core.sv
rtl/sacl_checker.sv
tb/sacl_tb_pkg.sv
tb/tb.sv
